@@ rtl/bgrd_pkg.sv @@
// shared types and constants for the bus gain ramp ducker
`default_nettype none

package bgrd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_BUS_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MUTED          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUCK_ENABLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUCK_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUCK_DEPTH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES         = 3'd7;

	localparam int GAIN_W   = 16;
	localparam int Q16_W    = 17;
	localparam int LEVEL_W  = 23;
	localparam int FRAME_W  = 12;
	localparam int FPB_W    = 13;
	localparam int RAMP_W   = 34;
	localparam int RAMP_FRAC  = 14;
	localparam int OUT_SHIFT  = 26;
	localparam int DIVIDEND_W = GAIN_W + RAMP_FRAC;
	localparam int N_CH       = 2;

	localparam logic [Q16_W-1:0]   UNITY_Q16     = 17'd65536;
	localparam logic [GAIN_W-1:0]  BUS_GAIN_RST  = 16'd4096;
	localparam logic [FPB_W-1:0]   FRAMES_RST    = 13'd256;
	localparam logic [LEVEL_W-1:0] PEAK_MAX      = 23'd8388607;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [FPB_W-1:0]      divisor;
	} div_req_t;

endpackage

`default_nettype wire

@@ rtl/bgrd_mul.sv @@
// shared registered multiplier
`default_nettype none

module bgrd_mul #(
	parameter int A_W = 24,
	parameter int B_W = 34
) (
	input  wire logic               clk,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic      [A_W+B_W-1:0] p
);

	logic [A_W+B_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

	assign p = p_q;

endmodule

`default_nettype wire

@@ rtl/bgrd_div.sv @@
// restoring divider for the per-frame ramp step
`default_nettype none

module bgrd_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire bgrd_pkg::div_req_t                  req,
	output logic                                     busy,
	output logic [bgrd_pkg::DIVIDEND_W-1:0]          quotient
);

	localparam int DW    = bgrd_pkg::DIVIDEND_W;
	localparam int VW    = bgrd_pkg::FPB_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [VW:0]      shifted;
	logic             fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			if (fits) begin
				rem_q <= VW'(shifted - {1'b0, dvs_q});
			end else begin
				rem_q <= shifted[VW-1:0];
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ rtl/bus_gain_ramp_ducker_top.sv @@
// bus gain ramp ducker: sequencer, state and output register
// within a block: S_RAMP, S_CH/S_CHW per channel, S_FIN; a new word is taken in S_IDLE
// first frame of a block adds the duck multiply (if enabled) and gain multiply on the
// shared multiplier, then the 30-step ramp divide
// reset: registers to their defaults, duck gain unity, block gain 4096, counters cleared
// a new word is taken while the previous result still waits in the output register
`default_nettype none

module bus_gain_ramp_ducker_top #(
	parameter int SAMPLE_BITS      = 24,
	parameter int MAX_BLOCK_FRAMES = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bgrd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [bgrd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_ch0,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_ch1,
	input  wire logic [bgrd_pkg::LEVEL_W-1:0]        sidechain_peak,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [SAMPLE_BITS-1:0]            out_ch0,
	output logic signed [SAMPLE_BITS-1:0]            out_ch1,
	output logic [bgrd_pkg::LEVEL_W-1:0]             block_peak,
	output logic                                     block_end
);

	localparam int SB   = SAMPLE_BITS;
	localparam int MA_W = SB > bgrd_pkg::Q16_W ? SB : bgrd_pkg::Q16_W;
	localparam int RW   = bgrd_pkg::RAMP_W;
	localparam int P_W  = MA_W + RW;
	localparam int PR_W = P_W + 1 - bgrd_pkg::OUT_SHIFT;
	localparam int GW   = bgrd_pkg::GAIN_W;
	localparam int QW   = bgrd_pkg::Q16_W;
	localparam int LW   = bgrd_pkg::LEVEL_W;
	localparam int FW   = bgrd_pkg::FRAME_W;
	localparam int NW   = bgrd_pkg::FPB_W;
	localparam int DW   = bgrd_pkg::DIVIDEND_W;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DUCK  = 10'b0000000010,
		S_DUCKW = 10'b0000000100,
		S_GAIN  = 10'b0000001000,
		S_GAINW = 10'b0000010000,
		S_DIV   = 10'b0000100000,
		S_RAMP  = 10'b0001000000,
		S_CH    = 10'b0010000000,
		S_CHW   = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [GW-1:0] bus_gain_q;
	logic          muted_q;
	logic          duck_en_q;
	logic [LW-1:0] duck_thr_q;
	logic [QW-1:0] duck_depth_q;
	logic [QW-1:0] attack_q;
	logic [QW-1:0] release_q;
	logic [NW-1:0] fpb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_gain_q   <= bgrd_pkg::BUS_GAIN_RST;
			muted_q      <= 1'b0;
			duck_en_q    <= 1'b0;
			duck_thr_q   <= '0;
			duck_depth_q <= '0;
			attack_q     <= bgrd_pkg::UNITY_Q16;
			release_q    <= bgrd_pkg::UNITY_Q16;
			fpb_q        <= bgrd_pkg::FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				bgrd_pkg::REG_BUS_GAIN:       bus_gain_q   <= cfg_wdata[GW-1:0];
				bgrd_pkg::REG_MUTED:          muted_q      <= cfg_wdata[0];
				bgrd_pkg::REG_DUCK_ENABLE:    duck_en_q    <= cfg_wdata[0];
				bgrd_pkg::REG_DUCK_THRESHOLD: duck_thr_q   <= cfg_wdata[LW-1:0];
				bgrd_pkg::REG_DUCK_DEPTH:     duck_depth_q <= cfg_wdata[QW-1:0];
				bgrd_pkg::REG_ATTACK_COEF:    attack_q     <= cfg_wdata[QW-1:0];
				bgrd_pkg::REG_RELEASE_COEF:   release_q    <= cfg_wdata[QW-1:0];
				bgrd_pkg::REG_FRAMES:         fpb_q        <= cfg_wdata[NW-1:0];
				default: ;
			endcase
		end
	end

	// state
	logic [QW-1:0] duck_gain_q;
	logic [GW-1:0] applied_q;
	logic [RW-1:0] ramp_q;
	logic [RW-1:0] step_q;
	logic          down_q;
	logic [FW-1:0] frame_q;
	logic [LW-1:0] peak_q;
	logic          last_q;
	logic          fall_q;
	logic          ch_q;
	logic [SB-1:0] smp_q [bgrd_pkg::N_CH];
	logic [SB-1:0] res_q [bgrd_pkg::N_CH];
	logic [LW-1:0] sc_q;

	logic          out_valid_q;
	logic [SB-1:0] out_q [bgrd_pkg::N_CH];
	logic [LW-1:0] out_peak_q;
	logic          out_end_q;

	// block length
	logic [NW-1:0] frames;
	logic          last_c;

	always_comb begin
		if (fpb_q == '0) begin
			frames = NW'(1);
		end else if (32'(fpb_q) > 32'(MAX_BLOCK_FRAMES)) begin
			frames = NW'(MAX_BLOCK_FRAMES);
		end else begin
			frames = fpb_q;
		end
	end

	assign last_c = ({1'b0, frame_q} + NW'(1)) >= frames;

	// duck rule
	logic [QW-1:0] depth_cl;
	logic [QW-1:0] target;
	logic          fall;
	logic [QW-1:0] dmag;
	logic [QW-1:0] coef_raw;
	logic [QW-1:0] coef;

	always_comb begin
		depth_cl = (duck_depth_q > bgrd_pkg::UNITY_Q16) ? bgrd_pkg::UNITY_Q16 : duck_depth_q;
		target   = (sc_q <= duck_thr_q) ? bgrd_pkg::UNITY_Q16
		                                : bgrd_pkg::UNITY_Q16 - depth_cl;
		fall     = target < duck_gain_q;
		dmag     = fall ? duck_gain_q - target : target - duck_gain_q;
		coef_raw = fall ? attack_q : release_q;
		coef     = (coef_raw > bgrd_pkg::UNITY_Q16) ? bgrd_pkg::UNITY_Q16 : coef_raw;
	end

	// channel magnitude
	logic [SB-1:0] raw;
	logic          neg;
	logic [SB-1:0] cmag;

	assign raw  = smp_q[ch_q];
	assign neg  = raw[SB-1];
	assign cmag = neg ? SB'(~raw + SB'(1)) : raw;

	// shared multiplier
	logic [MA_W-1:0] mul_a;
	logic [RW-1:0]   mul_b;
	logic [P_W-1:0]  mul_p;

	always_comb begin
		case (state_q)
			S_DUCK: begin
				mul_a = MA_W'(dmag);
				mul_b = RW'(coef);
			end
			S_GAIN: begin
				mul_a = MA_W'(duck_gain_q);
				mul_b = RW'(bus_gain_q);
			end
			S_CH: begin
				mul_a = MA_W'(cmag);
				mul_b = ramp_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	bgrd_mul #(
		.A_W(MA_W),
		.B_W(RW)
	) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (mul_p)
	);

	// rounding of the product
	logic [P_W:0]  rnd16;
	logic [P_W:0]  rnd26;
	logic [QW-1:0] delta;
	logic [GW-1:0] gain_new;
	logic [GW-1:0] diff;
	logic [PR_W-1:0] prod;
	logic [PR_W-1:0] sat;
	logic [SB-1:0]   res;
	logic [LW-1:0]   lvl;

	localparam logic [PR_W-1:0] SPOS = (PR_W'(1) << (SB - 1)) - PR_W'(1);
	localparam logic [PR_W-1:0] SNEG = PR_W'(1) << (SB - 1);

	always_comb begin
		rnd16    = {1'b0, mul_p} + (P_W+1)'(32768);
		rnd26    = {1'b0, mul_p} + ((P_W+1)'(1) << (bgrd_pkg::OUT_SHIFT - 1));
		delta    = rnd16[32:16];
		gain_new = muted_q ? '0 : rnd16[31:16];
		diff     = (gain_new >= applied_q) ? gain_new - applied_q : applied_q - gain_new;
		prod     = rnd26[P_W:bgrd_pkg::OUT_SHIFT];
		if (neg) begin
			sat = (prod > SNEG) ? SNEG : prod;
			res = SB'(~sat[SB-1:0] + SB'(1));
		end else begin
			sat = (prod > SPOS) ? SPOS : prod;
			res = sat[SB-1:0];
		end
		lvl = (sat > PR_W'(bgrd_pkg::PEAK_MAX)) ? bgrd_pkg::PEAK_MAX : sat[LW-1:0];
	end

	// ramp step divider
	bgrd_pkg::div_req_t div_req;
	logic               div_busy;
	logic [DW-1:0]      div_quo;

	assign div_req.start    = state_q == S_GAINW;
	assign div_req.dividend = {diff, {bgrd_pkg::RAMP_FRAC{1'b0}}};
	assign div_req.divisor  = frames;

	bgrd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.busy    (div_busy),
		.quotient(div_quo)
	);

	logic in_acc;
	logic out_load;

	assign in_ready = state_q == S_IDLE;
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			duck_gain_q <= bgrd_pkg::UNITY_Q16;
			applied_q   <= bgrd_pkg::BUS_GAIN_RST;
			ramp_q      <= '0;
			step_q      <= '0;
			down_q      <= 1'b0;
			frame_q     <= '0;
			peak_q      <= '0;
			last_q      <= 1'b0;
			fall_q      <= 1'b0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (frame_q != '0) begin
							state_q <= S_RAMP;
						end else if (duck_en_q) begin
							state_q <= S_DUCK;
						end else begin
							duck_gain_q <= bgrd_pkg::UNITY_Q16;
							state_q     <= S_GAIN;
						end
					end
				end
				S_DUCK: begin
					fall_q  <= fall;
					state_q <= S_DUCKW;
				end
				S_DUCKW: begin
					duck_gain_q <= fall_q ? duck_gain_q - delta : duck_gain_q + delta;
					state_q     <= S_GAIN;
				end
				S_GAIN: begin
					state_q <= S_GAINW;
				end
				S_GAINW: begin
					down_q    <= gain_new < applied_q;
					ramp_q    <= RW'({applied_q, {bgrd_pkg::RAMP_FRAC{1'b0}}});
					applied_q <= gain_new;
					peak_q    <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy) begin
						step_q  <= RW'(div_quo);
						state_q <= S_RAMP;
					end
				end
				S_RAMP: begin
					last_q <= last_c;
					if (last_c) begin
						ramp_q <= RW'({applied_q, {bgrd_pkg::RAMP_FRAC{1'b0}}});
					end else if (down_q) begin
						ramp_q <= (ramp_q >= step_q) ? ramp_q - step_q : '0;
					end else begin
						ramp_q <= ramp_q + step_q;
					end
					ch_q    <= 1'b0;
					state_q <= S_CH;
				end
				S_CH: begin
					state_q <= S_CHW;
				end
				S_CHW: begin
					if (lvl > peak_q) begin
						peak_q <= lvl;
					end
					if (ch_q == 1'(bgrd_pkg::N_CH - 1)) begin
						state_q <= S_FIN;
					end else begin
						ch_q    <= ~ch_q;
						state_q <= S_CH;
					end
				end
				S_FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						frame_q     <= last_q ? '0 : frame_q + FW'(1);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// word payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q[0] <= sample_ch0;
			smp_q[1] <= sample_ch1;
			sc_q     <= sidechain_peak;
		end
		if (state_q == S_CHW) begin
			res_q[ch_q] <= res;
		end
		if (out_load) begin
			out_q[0]   <= res_q[0];
			out_q[1]   <= res_q[1];
			out_peak_q <= last_q ? peak_q : '0;
			out_end_q  <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_ch0    = out_q[0];
	assign out_ch1    = out_q[1];
	assign block_peak = out_peak_q;
	assign block_end  = out_end_q;

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GAINW |=> div_busy)
		else $error("divider not started at block start");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input still ready after a word was taken");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == S_IDLE)
		else $error("finished word not presented");

	a_peak_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_end_q |-> out_peak_q == '0)
		else $error("peak reported before block end");

endmodule

`default_nettype wire
